@@ rtl/core/bws_pkg.sv @@
// shared constants for the weighted bin sampler
`timescale 1ns / 1ps

package bws_pkg;

   // default sizing handed to the top level
   localparam int DEF_MAX_BINS      = 64;
   localparam int DEF_WEIGHT_BITS   = 16;
   localparam int DEF_FRACTION_BITS = 16;

   // fixed widths of the cumulative sums and the result index
   localparam int CUM_BITS   = 22;
   localparam int INDEX_BITS = 6;

   // depth of the command queue between front and back end
   localparam int QUEUE_DEPTH = 4;

   // item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_DRAW = 1'b1;

   // result status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

endpackage

@@ rtl/core/bws_if.sv @@
// request and response channel interfaces of the weighted bin sampler
`timescale 1ns / 1ps

interface bws_req_if #(
   parameter int WEIGHT_BITS   = bws_pkg::DEF_WEIGHT_BITS,
   parameter int FRACTION_BITS = bws_pkg::DEF_FRACTION_BITS
);
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic [WEIGHT_BITS-1:0]   weight;
   logic                     last_weight;
   logic [FRACTION_BITS-1:0] uniform;

   modport source (output valid, kind, weight, last_weight, uniform, input ready);
   modport sink   (input valid, kind, weight, last_weight, uniform, output ready);
endinterface

interface bws_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bws_pkg::INDEX_BITS-1:0]  bin_index;
   logic                            status;

   modport source (output valid, bin_index, status, input ready);
   modport sink   (input valid, bin_index, status, output ready);
endinterface

@@ rtl/core/bws_front.sv @@
// front end: takes request items and classifies them into queue commands
`timescale 1ns / 1ps

module bws_front #(
   parameter int WEIGHT_BITS   = bws_pkg::DEF_WEIGHT_BITS,
   parameter int FRACTION_BITS = bws_pkg::DEF_FRACTION_BITS,
   parameter int DATA_W        = 16
) (
   input  logic              clock,
   input  logic              reset,
   bws_req_if.sink           req_chan,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output logic [DATA_W+1:0] cmd_data
);
   import bws_pkg::*;

   logic              cmd_valid_ff, cmd_valid_in;
   logic [DATA_W+1:0] cmd_data_ff, cmd_data_in;
   logic              take;
   logic              is_draw;

   // stage is free when empty or when the queue takes its item this cycle
   assign req_chan.ready = !cmd_valid_ff || cmd_ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign is_draw        = (req_chan.kind == KIND_DRAW);

   // pack the command: draw flag, last mark, then weight or fraction
   always_comb begin
      cmd_data_in  = cmd_data_ff;
      cmd_valid_in = cmd_valid_ff && !cmd_ready;
      if (take) begin
         cmd_valid_in = 1'b1;
         cmd_data_in  = {is_draw,
                         !is_draw && req_chan.last_weight,
                         is_draw ? DATA_W'(req_chan.uniform) : DATA_W'(req_chan.weight)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
      cmd_data_ff <= cmd_data_in;
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd_data  = cmd_data_ff;

endmodule

@@ rtl/core/bws_fifo.sv @@
// short command queue between the front and back end
`timescale 1ns / 1ps

module bws_fifo #(
   parameter int WIDTH = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import bws_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             push, pop;

   assign push_ready = (fill_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // fill never exceeds the depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   // a full queue refuses and cannot grow
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == CNT_W'(QUEUE_DEPTH)) && !pop |=> fill_ff == CNT_W'(QUEUE_DEPTH))
      else $error("full queue changed without a pop");

   // an empty queue has equal pointers
   a_ptr_fill: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule

@@ rtl/core/bws_back.sv @@
// back end: cumulative table, draw multiply, binary search and result register
`timescale 1ns / 1ps

module bws_back #(
   parameter int MAX_BINS      = bws_pkg::DEF_MAX_BINS,
   parameter int WEIGHT_BITS   = bws_pkg::DEF_WEIGHT_BITS,
   parameter int FRACTION_BITS = bws_pkg::DEF_FRACTION_BITS,
   parameter int DATA_W        = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  logic [DATA_W+1:0] cmd_data,
   bws_rsp_if.source         rsp_chan
);
   import bws_pkg::*;

   localparam int IDX_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CNT_W  = $clog2(MAX_BINS + 1);
   localparam int SUM_W  = ((CUM_BITS > WEIGHT_BITS) ? CUM_BITS : WEIGHT_BITS) + 1;
   localparam int PROD_W = FRACTION_BITS + CUM_BITS;
   localparam logic [CUM_BITS-1:0] CUM_MAX = '1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MUL    = 2'd1;
   localparam logic [1:0] ST_SEARCH = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   // cumulative sums, one entry per bin
   logic [CUM_BITS-1:0] cum_mem [MAX_BINS];
   logic [CUM_BITS-1:0] rd_data_ff;

   logic [1:0]               state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CUM_BITS-1:0]      total_ff, total_in;
   logic                     table_ready_ff, table_ready_in;
   logic                     start_new_ff, start_new_in;
   logic [FRACTION_BITS-1:0] uniform_ff, uniform_in;
   logic [PROD_W-1:0]        scaled_ff, scaled_in;
   logic [CNT_W-1:0]         lo_ff, lo_in;
   logic [CNT_W-1:0]         hi_ff, hi_in;
   logic [CNT_W-1:0]         mid_ff, mid_in;
   logic [CNT_W-1:0]         result_ff, result_in;
   logic                     fail_ff, fail_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]    rsp_bin_ff, rsp_bin_in;
   logic                     rsp_status_ff, rsp_status_in;

   logic                     cmd_draw, cmd_last;
   logic [WEIGHT_BITS-1:0]   cmd_weight;
   logic [FRACTION_BITS-1:0] cmd_uniform;
   logic                     take;
   logic [CNT_W-1:0]         eff_count;
   logic [CUM_BITS-1:0]      eff_total;
   logic [SUM_W-1:0]         sum;
   logic [CUM_BITS-1:0]      sat_sum;
   logic                     table_ok;
   logic                     wr_en, rd_en;
   logic [IDX_W-1:0]         wr_addr, rd_addr;
   logic                     above;
   logic [CNT_W:0]           mid_sum;
   logic [INDEX_BITS+CNT_W-1:0] bin_ext;

   // unpack the queue command
   assign cmd_draw    = cmd_data[DATA_W+1];
   assign cmd_last    = cmd_data[DATA_W];
   assign cmd_weight  = cmd_data[WEIGHT_BITS-1:0];
   assign cmd_uniform = cmd_data[FRACTION_BITS-1:0];

   assign cmd_ready = (state_ff == ST_IDLE);
   assign take      = cmd_valid && cmd_ready;

   // load path: restart the table if due, then add with saturation
   assign eff_count = start_new_ff ? '0 : count_ff;
   assign eff_total = start_new_ff ? '0 : total_ff;
   assign sum       = SUM_W'(eff_total) + SUM_W'(cmd_weight);
   assign sat_sum   = (sum > SUM_W'(CUM_MAX)) ? CUM_MAX : sum[CUM_BITS-1:0];
   assign wr_addr   = eff_count[IDX_W-1:0];
   assign table_ok  = table_ready_ff && (count_ff != '0) && (total_ff != '0);

   // search compare: entry k shifted up by the fraction width against u*total
   assign above   = {rd_data_ff, FRACTION_BITS'(0)} > scaled_ff;
   assign rd_addr = mid_in[IDX_W-1:0];
   assign bin_ext = {INDEX_BITS'(0), result_ff};

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      total_in       = total_ff;
      table_ready_in = table_ready_ff;
      start_new_in   = start_new_ff;
      uniform_in     = uniform_ff;
      scaled_in      = scaled_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      result_in      = result_ff;
      fail_in        = fail_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_bin_in     = rsp_bin_ff;
      rsp_status_in  = rsp_status_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      mid_sum        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (take && !cmd_draw) begin
               // one weight: store its running sum if there is room
               if (eff_count < CNT_W'(MAX_BINS)) begin
                  wr_en    = 1'b1;
                  count_in = eff_count + 1'b1;
                  total_in = sat_sum;
               end else begin
                  count_in = eff_count;
                  total_in = eff_total;
               end
               table_ready_in = cmd_last ? 1'b1 : (start_new_ff ? 1'b0 : table_ready_ff);
               start_new_in   = cmd_last;
            end else if (take) begin
               if (table_ok) begin
                  uniform_in = cmd_uniform;
                  state_in   = ST_MUL;
               end else begin
                  fail_in  = 1'b1;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_MUL: begin
            // scale the fraction and open the search over all bins
            scaled_in = PROD_W'(uniform_ff) * PROD_W'(total_ff);
            lo_in     = '0;
            hi_in     = count_ff;
            mid_in    = count_ff >> 1;
            rd_en     = 1'b1;
            state_in  = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (lo_ff == hi_ff) begin
               // clamp to the last bin when no entry lies above
               result_in = (lo_ff == count_ff) ? count_ff - 1'b1 : lo_ff;
               fail_in   = 1'b0;
               state_in  = ST_EMIT;
            end else begin
               if (above) begin
                  hi_in = mid_ff;
               end else begin
                  lo_in = mid_ff + 1'b1;
               end
               mid_sum = {1'b0, lo_in} + {1'b0, hi_in};
               mid_in  = mid_sum[CNT_W:1];
               rd_en   = (lo_in != hi_in);
            end
         end
         ST_EMIT: begin
            // hand over to the output register once it is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_bin_in    = fail_ff ? '0 : bin_ext[INDEX_BITS-1:0];
               rsp_status_in = fail_ff ? STATUS_EMPTY : STATUS_OK;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // table memory: one write port for loads, one registered read for the search
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cum_mem[wr_addr] <= sat_sum;
      end
      if (rd_en) begin
         rd_data_ff <= cum_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         total_ff       <= '0;
         table_ready_ff <= 1'b0;
         start_new_ff   <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         total_ff       <= total_in;
         table_ready_ff <= table_ready_in;
         start_new_ff   <= start_new_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      uniform_ff    <= uniform_in;
      scaled_ff     <= scaled_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      result_ff     <= result_in;
      fail_ff       <= fail_in;
      rsp_bin_ff    <= rsp_bin_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.bin_index = rsp_bin_ff;
   assign rsp_chan.status    = rsp_status_ff;

   // search window stays inside the loaded table
   a_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (lo_ff <= hi_ff) && (hi_ff <= count_ff))
      else $error("search window outside table");

   // a search only starts on a usable table
   a_mul_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> table_ready_ff && (total_ff != '0) && (count_ff != '0))
      else $error("draw multiply on empty table");

   // failed draws report bin zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_EMPTY) |-> (rsp_bin_ff == '0))
      else $error("failed draw with nonzero bin");

   // the table is never touched while a draw is in flight
   a_table_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |=> $stable(count_ff) && $stable(total_ff))
      else $error("table changed during a search");

endmodule

@@ rtl/core/weighted_bin_sampler.sv @@
// top level of the weighted bin sampler: front end, command queue, back end
//
//   channel    dir  handshake        payload
//   req_chan   in   valid / ready    kind, weight, last_weight, uniform
//   rsp_chan   out  valid / ready    bin_index, status
//
// the back end takes a load item in its idle state and stays idle; a draw passes
// through a multiply state, a binary search over the table memory, one probe
// per cycle, and an emit state, and no new item is taken until it is done.
// the front end takes an item every cycle while the queue has room.
// reset is synchronous and leaves no table loaded; the table memory is not cleared.
// either side may stall; the queue and result register keep them apart.
`timescale 1ns / 1ps

module weighted_bin_sampler #(
   parameter int MAX_BINS      = bws_pkg::DEF_MAX_BINS,
   parameter int WEIGHT_BITS   = bws_pkg::DEF_WEIGHT_BITS,
   parameter int FRACTION_BITS = bws_pkg::DEF_FRACTION_BITS
) (
   input  logic      clock,
   input  logic      reset,
   bws_req_if.sink   req_chan,
   bws_rsp_if.source rsp_chan
);
   import bws_pkg::*;

   localparam int DATA_W = (WEIGHT_BITS > FRACTION_BITS) ? WEIGHT_BITS : FRACTION_BITS;

   logic              fr_valid, fr_ready;
   logic [DATA_W+1:0] fr_data;
   logic              bk_valid, bk_ready;
   logic [DATA_W+1:0] bk_data;

   // classify incoming items
   bws_front #(
      .WEIGHT_BITS   (WEIGHT_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .DATA_W        (DATA_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (fr_valid),
      .cmd_ready (fr_ready),
      .cmd_data  (fr_data)
   );

   // queue between the two halves
   bws_fifo #(
      .WIDTH (DATA_W + 2)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  (fr_data),
      .pop_valid  (bk_valid),
      .pop_ready  (bk_ready),
      .pop_data   (bk_data)
   );

   // table keeping and draws
   bws_back #(
      .MAX_BINS      (MAX_BINS),
      .WEIGHT_BITS   (WEIGHT_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .DATA_W        (DATA_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (bk_valid),
      .cmd_ready (bk_ready),
      .cmd_data  (bk_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ tb/sv/weighted_bin_sampler_test.sv @@
// self-checking testbench of the weighted bin sampler: load and draw items against a predictor
`timescale 1ns / 1ps

module weighted_bin_sampler_test;
   import bws_pkg::*;

   localparam int NUM_BINS     = DEF_MAX_BINS;
   localparam int FRAC_BITS    = DEF_FRACTION_BITS;
   localparam longint SUM_MAX  = (64'd1 << CUM_BITS) - 1;
   localparam int RANDOM_ITEMS = 1350;
   localparam int TAIL_ITEMS   = 150;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int LIMIT_CYCLES = 400000;

   typedef struct {
      logic                       kind;
      logic [DEF_WEIGHT_BITS-1:0] weight;
      logic                       last_weight;
      logic [FRAC_BITS-1:0]       uniform;
   } sampler_item_type;

   typedef struct {
      logic [INDEX_BITS-1:0] bin_index;
      logic                  status;
   } draw_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bws_req_if req_chan ();
   bws_rsp_if rsp_chan ();

   weighted_bin_sampler u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor copy of the sampler state
   logic [CUM_BITS-1:0] cum_sums [NUM_BINS];
   int                  loaded_bins;
   logic [CUM_BITS-1:0] weight_total;
   bit                  table_valid;
   bit                  table_restart;

   sampler_item_type pending_items [$];
   draw_result_type  expected_draws [$];
   sampler_item_type next_item;

   int errors      = 0;
   int total_items = 0;
   int items_taken = 0;
   int send_gap    = 0;
   int recv_gap    = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;
   bit quiet_tail  = 1'b0;
   bit req_taken   = 1'b0;

   always #1 clock = ~clock;

   // apply one accepted item to the predictor, queueing the draw outcome
   task automatic apply_item(input sampler_item_type it);
      draw_result_type r;
      longint          sum;
      longint          scaled;
      int              pick;
      int              j;
      if (it.kind == KIND_LOAD) begin
         if (table_restart) begin
            loaded_bins   = 0;
            weight_total  = '0;
            table_valid   = 1'b0;
            table_restart = 1'b0;
         end
         // weights past the last bin are dropped
         if (loaded_bins < NUM_BINS) begin
            sum = longint'(weight_total) + longint'(it.weight);
            if (sum > SUM_MAX) sum = SUM_MAX;
            weight_total = sum[CUM_BITS-1:0];
            cum_sums[loaded_bins] = sum[CUM_BITS-1:0];
            loaded_bins++;
         end
         if (it.last_weight) begin
            table_valid   = 1'b1;
            table_restart = 1'b1;
         end
      end else begin
         if (!table_valid || loaded_bins == 0 || weight_total == 0) begin
            r.bin_index = '0;
            r.status    = STATUS_EMPTY;
         end else begin
            // exact compare of u*total against each cumulative sum
            scaled = longint'(it.uniform) * longint'(weight_total);
            pick   = loaded_bins - 1;
            for (j = loaded_bins - 1; j >= 0; j--) begin
               if (scaled < (longint'(cum_sums[j]) << FRAC_BITS)) pick = j;
            end
            r.bin_index = pick[INDEX_BITS-1:0];
            r.status    = STATUS_OK;
         end
         expected_draws.push_back(r);
      end
   endtask

   task automatic queue_load(input int w, input bit last);
      sampler_item_type it;
      it.kind        = KIND_LOAD;
      it.weight      = w[DEF_WEIGHT_BITS-1:0];
      it.last_weight = last;
      it.uniform     = FRAC_BITS'($urandom);
      pending_items.push_back(it);
   endtask

   task automatic queue_draw(input int u);
      sampler_item_type it;
      it.kind        = KIND_DRAW;
      it.weight      = DEF_WEIGHT_BITS'($urandom);
      it.last_weight = 1'($urandom_range(0, 1));
      it.uniform     = u[FRAC_BITS-1:0];
      pending_items.push_back(it);
   endtask

   function automatic int pick_weight();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 0;
      if (r == 1) return 'hFFFF;
      if (r < 4) return $urandom_range(1, 15);
      return $urandom_range(0, 16'hFFFF);
   endfunction

   function automatic int pick_uniform();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return 'hFFFF;
      return $urandom_range(0, 16'hFFFF);
   endfunction

   // one table of n weights, the last one marked, with an odd draw mid-load
   task automatic queue_table(input int n, input bit all_max);
      int i;
      for (i = 0; i < n; i++) begin
         queue_load(all_max ? 16'hFFFF : pick_weight(), i == n - 1);
         if (i != n - 1 && $urandom_range(0, 19) == 0) queue_draw(pick_uniform());
      end
   endtask

   // random part: mostly whole tables followed by draws, some noise
   task automatic fill_random();
      sampler_item_type it;
      int               r;
      int               n;
      int               i;
      while (pending_items.size() < RANDOM_ITEMS + 25) begin
         r = $urandom_range(0, 99);
         if (r < 2) begin
            queue_table(NUM_BINS, 1'b1);
            repeat ($urandom_range(2, 6)) queue_draw(pick_uniform());
         end else if (r < 70) begin
            n = $urandom_range(0, 29);
            if (n == 0)      n = $urandom_range(NUM_BINS + 1, NUM_BINS + 8);
            else if (n < 4)  n = $urandom_range(9, NUM_BINS);
            else             n = $urandom_range(1, 8);
            queue_table(n, 1'b0);
            repeat ($urandom_range(1, 6)) queue_draw(pick_uniform());
         end else if (r < 85) begin
            it.kind        = 1'($urandom_range(0, 1));
            it.weight      = DEF_WEIGHT_BITS'($urandom);
            it.last_weight = 1'($urandom_range(0, 1));
            it.uniform     = FRAC_BITS'($urandom);
            pending_items.push_back(it);
         end else begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) queue_draw(pick_uniform());
         end
      end
   endtask

   // sender: holds an item until taken, with random gap bursts
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (send_gap > 0) begin
            req_chan.valid <= 1'b0;
            send_gap = send_gap - 1;
         end else if (pending_items.size() > 0) begin
            next_item = pending_items.pop_front();
            req_chan.kind        <= next_item.kind;
            req_chan.weight      <= next_item.weight;
            req_chan.last_weight <= next_item.last_weight;
            req_chan.uniform     <= next_item.uniform;
            req_chan.valid       <= 1'b1;
            if (!quiet_tail && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 16);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off once, so the queue fills and the input stalls
   always @(negedge clock) begin
      if (!hold_done && items_taken >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver: ready with random stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         rsp_chan.ready <= 1'b0;
         recv_gap = recv_gap - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (!quiet_tail && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 16);
      end
   end

   // monitor: check results, feed accepted items to the predictor
   always @(posedge clock) begin
      draw_result_type want;
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_draws.size() == 0) begin
               $display("%0t: unexpected result bin %0d status %0d", $time,
                        rsp_chan.bin_index, rsp_chan.status);
               errors++;
            end else begin
               want = expected_draws.pop_front();
               if (rsp_chan.bin_index !== want.bin_index || rsp_chan.status !== want.status) begin
                  $display("%0t: expected bin %0d status %0d, got bin %0d status %0d", $time,
                           want.bin_index, want.status, rsp_chan.bin_index, rsp_chan.status);
                  errors++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            next_item.kind        = req_chan.kind;
            next_item.weight      = req_chan.weight;
            next_item.last_weight = req_chan.last_weight;
            next_item.uniform     = req_chan.uniform;
            apply_item(next_item);
            items_taken++;
         end
         quiet_tail = items_taken >= total_items - TAIL_ITEMS;
      end
   end

   // overall limit on run length
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("weighted_bin_sampler_test: FAIL");
      $finish;
   end

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.kind        = KIND_LOAD;
      req_chan.weight      = '0;
      req_chan.last_weight = 1'b0;
      req_chan.uniform     = '0;
      rsp_chan.ready       = 1'b0;
      loaded_bins   = 0;
      weight_total  = '0;
      table_valid   = 1'b0;
      table_restart = 1'b1;

      // draw with no table, then an all-zero table
      queue_draw(16'hFFFF);
      queue_load(0, 1'b1);
      queue_draw(0);
      // extreme weights with a zero bin between
      queue_load(16'hFFFF, 1'b0);
      queue_load(0, 1'b0);
      queue_load(1, 1'b0);
      queue_load(16'hFFFF, 1'b1);
      queue_draw(0);
      queue_draw(16'hFFFF);
      queue_draw(16'h8000);
      queue_draw(16'h7FFF);
      // draw while a new table is half loaded
      queue_load(5, 1'b0);
      queue_draw(16'h1234);
      queue_load(7, 1'b1);
      queue_draw(0);
      queue_draw(16'hFFFF);
      queue_draw(16'h5000);
      // single bin
      queue_load(1000, 1'b1);
      queue_draw($urandom);
      // zero weights around one live bin
      queue_load(0, 1'b0);
      queue_load(10, 1'b0);
      queue_load(0, 1'b1);
      queue_draw(0);
      queue_draw(16'hFFFF);
      fill_random();
      total_items = pending_items.size();

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      while (items_taken < total_items) @(posedge clock);
      while (expected_draws.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && expected_draws.size() == 0) begin
         $display("weighted_bin_sampler_test: PASS");
      end else begin
         $display("weighted_bin_sampler_test: FAIL");
      end
      $finish;
   end

endmodule
